[rtl/core/ssdi_pkg.sv]
// shared types, constants and helpers for the sample to display index pipeline
package ssdi_pkg;

    typedef enum logic [2:0]
    {
        MODE_REAL  = 3'd0,
        MODE_IMAG  = 3'd1,
        MODE_MAG   = 3'd2,
        MODE_DB10  = 3'd3,
        MODE_DB20  = 3'd4,
        MODE_PHASE = 3'd5
    } value_mode_t;

    typedef enum logic [2:0]
    {
        CFG_COMPLEX   = 3'd0,
        CFG_MODE      = 3'd1,
        CFG_RANGE_MIN = 3'd2,
        CFG_RANGE_MAX = 3'd3,
        CFG_FLOOR     = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        KIND_LOW  = 2'd0,
        KIND_HIGH = 2'd1,
        KIND_DIV  = 2'd2
    } scale_kind_t;

    typedef struct packed
    {
        logic valid;
        logic pixel;
    } pix_tag_t;

    localparam int LOG_FRAC     = 24;
    localparam int LOG_STEPS    = 24;
    localparam int LOG_LAT      = LOG_STEPS + 5;
    localparam int DB_SHIFT     = LOG_FRAC + 28;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int CORDIC_XW    = 44;
    localparam int CORDIC_ZW    = 27;
    localparam int CORDIC_SCALE = 40;
    localparam int QUOT_BITS    = 8;
    localparam int SCALE_LAT    = QUOT_BITS + 3;
    localparam int SCALE_SPAN   = 254;
    localparam int OUT_MAX      = 8388607;
    localparam int OUT_MIN      = -8388608;

    localparam logic [31:0] DB10_K = 32'd808071242;

    localparam logic [21:0] ATAN_DEG_Q16 [0:CORDIC_STEPS-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd1
    };

    localparam logic [7:0] COLOR_MASKED = 8'd0;
    localparam logic [7:0] COLOR_LOW    = 8'd1;
    localparam logic [7:0] COLOR_HIGH   = 8'd255;

    function automatic int value_width(int s, int f);
        return (s + f + 2 > 25) ? s + f + 2 : 25;
    endfunction

endpackage

[rtl/core/ssdi_mag.sv]
// magnitude pipeline: squares, then one square root digit per stage
module ssdi_mag #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                   clk,
    input  logic signed [SAMPLE_BITS-1:0]          re,
    input  logic signed [SAMPLE_BITS-1:0]          im,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0]   mag
);
    import ssdi_pkg::*;

    localparam int K  = SAMPLE_BITS + FRACTION_BITS;
    localparam int SW = 2 * SAMPLE_BITS;
    localparam int RW = K + 2;

    logic signed [SW-1:0] re_sq_reg;
    logic signed [SW-1:0] im_sq_reg;
    logic [SW-1:0]        sq_reg   [0:K];
    logic [RW-1:0]        rem_reg  [0:K];
    logic [K-1:0]         root_reg [0:K];

    always_ff @(posedge clk)
    begin
        re_sq_reg   <= re * re;
        im_sq_reg   <= im * im;
        sq_reg[0]   <= $unsigned(re_sq_reg) + $unsigned(im_sq_reg);
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
    end

    for (genvar j = 0; j < K; j++)
    begin : g_root
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;

        assign cur   = {rem_reg[j], sq_reg[j][SW-1 -: 2]};
        assign trial = (RW+2)'({root_reg[j], 2'b01});

        always_ff @(posedge clk)
        begin
            sq_reg[j+1] <= sq_reg[j] << 2;
            if (cur >= trial)
            begin
                rem_reg[j+1]  <= RW'(cur - trial);
                root_reg[j+1] <= {root_reg[j][K-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j+1]  <= RW'(cur);
                root_reg[j+1] <= {root_reg[j][K-2:0], 1'b0};
            end
        end
    end

    assign mag = root_reg[K];

endmodule

[rtl/core/ssdi_log.sv]
// decibel pipeline: floor, normalize, log2 by repeated squaring, scale and round
module ssdi_log #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                            clk,
    input  logic [SAMPLE_BITS+FRACTION_BITS-1:0]            mag,
    input  logic [15:0]                                     mag_floor,
    input  logic                                            db20,
    output logic signed [ssdi_pkg::value_width(SAMPLE_BITS, FRACTION_BITS)-1:0] db
);
    import ssdi_pkg::*;

    localparam int K  = SAMPLE_BITS + FRACTION_BITS;
    localparam int MW = (K > 16) ? K : 16;
    localparam int EW = $clog2(MW);
    localparam int LW = LOG_FRAC + EW + 2;
    localparam int PW = LW + 32;
    localparam int VW = value_width(SAMPLE_BITS, FRACTION_BITS);
    localparam int SH = DB_SHIFT - FRACTION_BITS;

    logic [MW-1:0]        m_reg;
    logic [EW-1:0]        e1_reg;
    logic [30:0]          y_reg    [0:LOG_STEPS];
    logic [EW-1:0]        e_reg    [0:LOG_STEPS];
    logic [LOG_FRAC-1:0]  frac_reg [0:LOG_STEPS];
    logic signed [PW-1:0] p_hi_reg;
    logic signed [PW-1:0] p_lo_reg;
    logic signed [PW-1:0] p_reg;
    logic signed [VW-1:0] db_reg;

    logic [MW-1:0]        fl;
    logic [MW-1:0]        m_ext;
    logic [MW-1:0]        m_next;
    logic [EW-1:0]        e_next;
    logic [MW+29:0]       wide;
    logic signed [LW-1:0] lval;
    logic [31:0]          k;
    logic [PW-1:0]        p_abs;
    logic [PW-1:0]        r;

    always_comb
    begin
        fl     = (mag_floor == 16'd0) ? MW'(1) : MW'(mag_floor);
        m_ext  = MW'(mag);
        m_next = (m_ext < fl) ? fl : m_ext;
        e_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (m_next[i])
            begin
                e_next = EW'(i);
            end
        end
    end

    assign wide = {m_reg, 30'b0} >> e1_reg;

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        e1_reg      <= e_next;
        y_reg[0]    <= wide[30:0];
        e_reg[0]    <= e1_reg;
        frac_reg[0] <= '0;
    end

    for (genvar j = 0; j < LOG_STEPS; j++)
    begin : g_sq
        logic [61:0] pr;
        logic [31:0] t;

        assign pr = 62'(y_reg[j]) * 62'(y_reg[j]);
        assign t  = pr[61:30];

        always_ff @(posedge clk)
        begin
            e_reg[j+1]    <= e_reg[j];
            y_reg[j+1]    <= t[31] ? t[31:1] : t[30:0];
            frac_reg[j+1] <= {frac_reg[j][LOG_FRAC-2:0], t[31]};
        end
    end

    always_comb
    begin
        lval  = signed'(((LW'(e_reg[LOG_STEPS]) - LW'(FRACTION_BITS)) << LOG_FRAC)
                | LW'(frac_reg[LOG_STEPS]));
        k     = db20 ? (DB10_K << 1) : DB10_K;
        p_abs = (p_reg < 0) ? $unsigned(-p_reg) : $unsigned(p_reg);
        r     = (p_abs + (PW'(1) << (SH - 1))) >> SH;
    end

    always_ff @(posedge clk)
    begin
        p_hi_reg <= PW'(lval) * PW'(signed'({1'b0, k[31:16]}));
        p_lo_reg <= PW'(lval) * PW'(signed'({1'b0, k[15:0]}));
        p_reg    <= (p_hi_reg <<< 16) + p_lo_reg;
        db_reg   <= (p_reg < 0) ? -signed'(VW'(r)) : signed'(VW'(r));
    end

    assign db = db_reg;

endmodule

[rtl/core/ssdi_cordic.sv]
// phase pipeline: half-turn pre-rotation, vectoring cordic in degrees, round and clamp
module ssdi_cordic #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                           clk,
    input  logic signed [SAMPLE_BITS-1:0]  re,
    input  logic signed [SAMPLE_BITS-1:0]  im,
    output logic signed [ssdi_pkg::value_width(SAMPLE_BITS, FRACTION_BITS)-1:0] phase
);
    import ssdi_pkg::*;

    localparam int XW = CORDIC_XW;
    localparam int ZW = CORDIC_ZW;
    localparam int VW = value_width(SAMPLE_BITS, FRACTION_BITS);
    localparam int SH = 16 - FRACTION_BITS;
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] RND =
        (SH > 0) ? (ZW'(1) <<< ((SH > 0) ? SH - 1 : 0)) : '0;
    localparam logic signed [ZW-1:0] LIM = ZW'(180) <<< FRACTION_BITS;

    logic signed [XW-1:0] x_reg    [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg    [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg    [0:CORDIC_STEPS];
    logic                 zero_reg [0:CORDIC_STEPS];
    logic signed [VW-1:0] phase_reg;

    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [ZW-1:0] zr;

    assign x0 = XW'(re) <<< (CORDIC_SCALE - SAMPLE_BITS);
    assign y0 = XW'(im) <<< (CORDIC_SCALE - SAMPLE_BITS);

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (re == '0) && (im == '0);
        if (re < 0)
        begin
            x_reg[0] <= -x0;
            y_reg[0] <= -y0;
            z_reg[0] <= (im >= 0) ? HALF_TURN : -HALF_TURN;
        end
        else
        begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            zero_reg[j+1] <= zero_reg[j];
            if (y_reg[j] < 0)
            begin
                x_reg[j+1] <= x_reg[j] - (y_reg[j] >>> j);
                y_reg[j+1] <= y_reg[j] + (x_reg[j] >>> j);
                z_reg[j+1] <= z_reg[j] - signed'(ZW'(ATAN_DEG_Q16[j]));
            end
            else
            begin
                x_reg[j+1] <= x_reg[j] + (y_reg[j] >>> j);
                y_reg[j+1] <= y_reg[j] - (x_reg[j] >>> j);
                z_reg[j+1] <= z_reg[j] + signed'(ZW'(ATAN_DEG_Q16[j]));
            end
        end
    end

    assign zr = (z_reg[CORDIC_STEPS] + RND) >>> SH;

    always_ff @(posedge clk)
    begin
        if (zero_reg[CORDIC_STEPS])
        begin
            phase_reg <= '0;
        end
        else if (zr > LIM)
        begin
            phase_reg <= VW'(LIM);
        end
        else if (zr < -LIM)
        begin
            phase_reg <= VW'(-LIM);
        end
        else
        begin
            phase_reg <= VW'(zr);
        end
    end

    assign phase = phase_reg;

endmodule

[rtl/core/ssdi_scale.sv]
// colormap scaling: range compare, times 254, eight-stage restoring divide
module ssdi_scale (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ssdi_pkg::pix_tag_t       tag,
    input  logic signed [23:0]       value,
    input  logic signed [23:0]       range_min,
    input  logic signed [23:0]       range_max,
    output logic                     done,
    output logic [7:0]               color_index,
    output logic signed [23:0]       display_value
);
    import ssdi_pkg::*;

    localparam int NW = 32;

    pix_tag_t             tag1_reg;
    logic signed [23:0]   v1_reg;
    logic [23:0]          dif_reg;
    logic [23:0]          span1_reg;
    scale_kind_t          kind1_reg;

    pix_tag_t             tag_reg  [0:QUOT_BITS];
    logic signed [23:0]   v_reg    [0:QUOT_BITS];
    logic [23:0]          span_reg [0:QUOT_BITS];
    scale_kind_t          kind_reg [0:QUOT_BITS];
    logic [NW-1:0]        rem_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg    [0:QUOT_BITS];

    logic                 done_reg;
    logic [7:0]           color_reg;
    logic signed [23:0]   disp_reg;

    logic signed [24:0]   dif;
    logic signed [24:0]   span;
    scale_kind_t          kind_next;
    logic [7:0]           color_next;

    always_comb
    begin
        dif  = 25'(value) - 25'(range_min);
        span = 25'(range_max) - 25'(range_min);
        priority if (range_max <= range_min)
        begin
            kind_next = (value > range_min) ? KIND_HIGH : KIND_LOW;
        end
        else if (value <= range_min)
        begin
            kind_next = KIND_LOW;
        end
        else if (value >= range_max)
        begin
            kind_next = KIND_HIGH;
        end
        else
        begin
            kind_next = KIND_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg   <= '0;
            tag_reg[0] <= '0;
        end
        else
        begin
            tag1_reg   <= tag;
            tag_reg[0] <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg      <= value;
        dif_reg     <= dif[23:0];
        span1_reg   <= span[23:0];
        kind1_reg   <= kind_next;
        v_reg[0]    <= v1_reg;
        span_reg[0] <= span1_reg;
        kind_reg[0] <= kind1_reg;
        rem_reg[0]  <= NW'(dif_reg) * NW'(SCALE_SPAN);
        q_reg[0]    <= '0;
    end

    for (genvar j = 0; j < QUOT_BITS; j++)
    begin : g_div
        logic [NW-1:0] trial;

        assign trial = NW'(span_reg[j]) << (QUOT_BITS - 1 - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j+1] <= '0;
            end
            else
            begin
                tag_reg[j+1] <= tag_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            v_reg[j+1]    <= v_reg[j];
            span_reg[j+1] <= span_reg[j];
            kind_reg[j+1] <= kind_reg[j];
            if (rem_reg[j] >= trial)
            begin
                rem_reg[j+1] <= rem_reg[j] - trial;
                q_reg[j+1]   <= {q_reg[j][QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j+1] <= rem_reg[j];
                q_reg[j+1]   <= {q_reg[j][QUOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        unique case (kind_reg[QUOT_BITS])
            KIND_LOW:  color_next = COLOR_LOW;
            KIND_HIGH: color_next = COLOR_HIGH;
            KIND_DIV:  color_next = COLOR_LOW + q_reg[QUOT_BITS];
            default:   color_next = COLOR_LOW;
        endcase
        if (!tag_reg[QUOT_BITS].pixel)
        begin
            color_next = COLOR_MASKED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag_reg[QUOT_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
        disp_reg  <= v_reg[QUOT_BITS];
    end

    assign done          = done_reg;
    assign color_index   = color_reg;
    assign display_value = disp_reg;

endmodule

[rtl/core/sar_sample_to_display_index.sv]
// top level: radar pixel to display value and colormap index, fully pipelined
//
// channel   | signals                                  | handshake
// ----------+------------------------------------------+------------------------------
// pixel in  | start, busy, sample_re/im, pixel_valid   | taken when start and !busy
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data| written when valid and ready
// result    | done, color_index, display_value         | one-cycle strobe on done
//
// one pixel per cycle, every cycle; busy and cfg_ready are constant
// the path from request to done is set by the square root stages, the log2 squaring chain and the divider
// reset clears every valid bit and loads the register defaults
// done cannot be held off; each result shows for exactly one cycle
module sar_sample_to_display_index #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_BITS-1:0]  sample_re,
    input  logic signed [SAMPLE_BITS-1:0]  sample_im,
    input  logic                           pixel_valid,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [23:0]                    cfg_data,
    output logic                           done,
    output logic [7:0]                     color_index,
    output logic signed [23:0]             display_value
);
    import ssdi_pkg::*;

    localparam int K    = SAMPLE_BITS + FRACTION_BITS;
    localparam int VW   = value_width(SAMPLE_BITS, FRACTION_BITS);
    localparam int LM   = K + 2;
    localparam int T    = LM + LOG_LAT;
    localparam int PD   = T - CORDIC_LAT;
    localparam int DW   = 2 * SAMPLE_BITS + 1;
    localparam int LTOT = T + SCALE_LAT + 2;
    localparam logic signed [VW-1:0] V_MAX = VW'(OUT_MAX);
    localparam logic signed [VW-1:0] V_MIN = VW'(OUT_MIN);

    logic               complex_reg;
    value_mode_t        mode_reg;
    logic signed [23:0] min_reg;
    logic signed [23:0] max_reg;
    logic [15:0]        floor_reg;

    logic                          in_vld_reg;
    logic                          in_pix_reg;
    logic signed [SAMPLE_BITS-1:0] in_re_reg;
    logic signed [SAMPLE_BITS-1:0] in_im_reg;

    logic [DW-1:0]      smp_dly_reg [0:T-1];
    logic               vld_dly_reg [0:T-1];
    logic [K-1:0]       mag_dly_reg [0:LOG_LAT-1];
    logic [VW-1:0]      ph_dly_reg  [0:PD-1];

    logic [K-1:0]         mag;
    logic signed [VW-1:0] db;
    logic signed [VW-1:0] phase;

    logic signed [SAMPLE_BITS-1:0] re_d;
    logic signed [SAMPLE_BITS-1:0] im_d;
    logic                          pix_d;
    logic signed [VW-1:0]          v_sel;
    logic signed [23:0]            v_sat;

    pix_tag_t           val_tag_reg;
    logic signed [23:0] val_reg;

    logic accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complex_reg <= 1'b1;
            mode_reg    <= MODE_MAG;
            min_reg     <= 24'sd0;
            max_reg     <= 24'sd65280;
            floor_reg   <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COMPLEX:   complex_reg <= cfg_data[0];
                CFG_MODE:      mode_reg    <= value_mode_t'(cfg_data[2:0]);
                CFG_RANGE_MIN: min_reg     <= signed'(cfg_data);
                CFG_RANGE_MAX: max_reg     <= signed'(cfg_data);
                CFG_FLOOR:     floor_reg   <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // input stage, imag forced to zero for real-only samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        in_pix_reg <= pixel_valid;
        in_re_reg  <= sample_re;
        in_im_reg  <= complex_reg ? sample_im : '0;
    end

    ssdi_mag #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mag (
        .clk (clk),
        .re  (in_re_reg),
        .im  (in_im_reg),
        .mag (mag)
    );

    ssdi_log #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_log (
        .clk       (clk),
        .mag       (mag),
        .mag_floor (floor_reg),
        .db20      (mode_reg == MODE_DB20),
        .db        (db)
    );

    ssdi_cordic #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cordic (
        .clk   (clk),
        .re    (in_re_reg),
        .im    (in_im_reg),
        .phase (phase)
    );

    // alignment delays up to the value select stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < T; i++)
            begin
                vld_dly_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_dly_reg[0] <= in_vld_reg;
            for (int i = 1; i < T; i++)
            begin
                vld_dly_reg[i] <= vld_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_dly_reg[0] <= {in_pix_reg, in_im_reg, in_re_reg};
        for (int i = 1; i < T; i++)
        begin
            smp_dly_reg[i] <= smp_dly_reg[i-1];
        end
        mag_dly_reg[0] <= mag;
        for (int i = 1; i < LOG_LAT; i++)
        begin
            mag_dly_reg[i] <= mag_dly_reg[i-1];
        end
        ph_dly_reg[0] <= phase;
        for (int i = 1; i < PD; i++)
        begin
            ph_dly_reg[i] <= ph_dly_reg[i-1];
        end
    end

    assign re_d  = signed'(smp_dly_reg[T-1][SAMPLE_BITS-1:0]);
    assign im_d  = signed'(smp_dly_reg[T-1][2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign pix_d = smp_dly_reg[T-1][DW-1];

    always_comb
    begin
        unique case (mode_reg)
            MODE_REAL:  v_sel = VW'(re_d) <<< FRACTION_BITS;
            MODE_IMAG:  v_sel = VW'(im_d) <<< FRACTION_BITS;
            MODE_MAG:   v_sel = signed'(VW'(mag_dly_reg[LOG_LAT-1]));
            MODE_DB10:  v_sel = db;
            MODE_DB20:  v_sel = db;
            MODE_PHASE: v_sel = complex_reg ? signed'(ph_dly_reg[PD-1]) : '0;
            default:    v_sel = '0;
        endcase
        if (v_sel > V_MAX)
        begin
            v_sat = 24'(V_MAX);
        end
        else if (v_sel < V_MIN)
        begin
            v_sat = 24'(V_MIN);
        end
        else
        begin
            v_sat = 24'(v_sel);
        end
        if (!pix_d)
        begin
            v_sat = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_tag_reg <= '0;
        end
        else
        begin
            val_tag_reg <= '{valid: vld_dly_reg[T-1], pixel: pix_d};
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= v_sat;
    end

    ssdi_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag           (val_tag_reg),
        .value         (val_reg),
        .range_min     (min_reg),
        .range_max     (max_reg),
        .done          (done),
        .color_index   (color_index),
        .display_value (display_value)
    );

    // masked pixels alone give index zero, and they show a zero value
    a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (color_index != COLOR_MASKED) || (display_value == 24'sd0))
        else $error("index zero with a nonzero display value");

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LTOT done)
        else $error("request did not produce a result on time");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LTOT))
        else $error("result without a matching request");

endmodule

[sim/sar_sample_to_display_index_checker.sv]
// checker: predicts display value and color index per pixel request and compares results
`timescale 1ns / 1ps
module sar_sample_to_display_index_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    input  logic               pixel_valid,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               done,
    input  logic [7:0]         color_index,
    input  logic signed [23:0] display_value,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);
    import ssdi_pkg::*;

    typedef struct
    {
        logic [7:0]         color;
        logic signed [23:0] value;
    } pixel_out_t;

    pixel_out_t         expected_pixels[$];
    logic               cplx;
    logic [2:0]         mode;
    logic signed [23:0] range_lo;
    logic signed [23:0] range_hi;
    logic [15:0]        mag_floor;

    function automatic longint isqrt_q8(longint unsigned s);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned pair;
        longint unsigned trial;
        rem = 0;
        root = 0;
        for (int k = 23; k >= 0; k--)
        begin
            pair = 0;
            if (k >= 8)
                pair = (s >> (2 * (k - 8))) & 3;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return longint'(root);
    endfunction

    function automatic longint log2_q24(longint unsigned m);
        int e;
        longint unsigned y;
        longint frac;
        e = 0;
        frac = 0;
        while (e < 63 && (m >> (e + 1)) != 0)
            e++;
        y = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
        for (int i = 0; i < 24; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(e) - 8) * (longint'(1) << 24) + frac;
    endfunction

    function automatic longint decibels(longint mag, longint k);
        longint unsigned fl;
        longint unsigned mm;
        longint p;
        longint unsigned a;
        longint r;
        fl = (mag_floor == 0) ? 1 : mag_floor;
        mm = (longint'(mag) < longint'(fl)) ? fl : mag;
        p = log2_q24(mm) * k;
        a = (p < 0) ? -p : p;
        r = longint'((a + (64'd1 << 43)) >> 44);
        return (p < 0) ? -r : r;
    endfunction

    function automatic longint phase_deg(longint re, longint im);
        longint x;
        longint y;
        longint z;
        longint xn;
        if (re == 0 && im == 0)
            return 0;
        z = 0;
        x = re * (longint'(1) << 24);
        y = im * (longint'(1) << 24);
        if (x < 0)
        begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 24; i++)
        begin
            if (y < 0)
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_DEG_Q16[i]);
            end
            else
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_DEG_Q16[i]);
            end
            x = xn;
        end
        z = (z + 128) >>> 8;
        if (z > 180 * 256)
            z = 180 * 256;
        if (z < -180 * 256)
            z = -180 * 256;
        return z;
    endfunction

    function automatic pixel_out_t predict_pixel(longint re, longint im, logic pv);
        pixel_out_t o;
        longint mag;
        longint v;
        longint lo;
        longint hi;
        lo = range_lo;
        hi = range_hi;
        o.color = COLOR_MASKED;
        o.value = '0;
        if (!pv)
            return o;
        if (cplx)
            mag = isqrt_q8(longint'(re * re + im * im));
        else
            mag = ((re < 0) ? -re : re) << 8;
        case (mode)
            MODE_REAL:  v = re * 256;
            MODE_IMAG:  v = cplx ? im * 256 : 0;
            MODE_MAG:   v = mag;
            MODE_DB10:  v = decibels(mag, longint'(DB10_K));
            MODE_DB20:  v = decibels(mag, 2 * longint'(DB10_K));
            MODE_PHASE: v = cplx ? phase_deg(re, im) : 0;
            default:    v = 0;
        endcase
        if (v > OUT_MAX)
            v = OUT_MAX;
        if (v < OUT_MIN)
            v = OUT_MIN;
        if (hi <= lo)
            o.color = (v > lo) ? COLOR_HIGH : COLOR_LOW;
        else if (v <= lo)
            o.color = COLOR_LOW;
        else if (v >= hi)
            o.color = COLOR_HIGH;
        else
            o.color = 8'(1 + ((v - lo) * 254) / (hi - lo));
        o.value = v[23:0];
        return o;
    endfunction

    assign pending_count = expected_pixels.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_out_t got;
        pixel_out_t want;
        if (!rst_n)
        begin
            cplx <= 1'b1;
            mode <= MODE_MAG;
            range_lo <= 24'sd0;
            range_hi <= 24'sd65280;
            mag_floor <= 16'd1;
            fail_count <= 0;
            result_count <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (start && !busy)
                expected_pixels.push_back(predict_pixel(sample_re, sample_im, pixel_valid));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_COMPLEX:   cplx <= cfg_data[0];
                    CFG_MODE:      mode <= cfg_data[2:0];
                    CFG_RANGE_MIN: range_lo <= cfg_data;
                    CFG_RANGE_MAX: range_hi <= cfg_data;
                    CFG_FLOOR:     mag_floor <= cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (done)
            begin
                result_count <= result_count + 1;
                got.color = color_index;
                got.value = display_value;
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result color %0d value %0d",
                             $time, got.color, got.value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.color !== want.color || got.value !== want.value)
                    begin
                        $display("%0t: mismatch color exp %0d got %0d, value exp %0d got %0d",
                                 $time, want.color, got.color, want.value, got.value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/sar_sample_to_display_index_tb.sv]
// testbench top: pixel and register stimulus for the sample to display index block
`timescale 1ns / 1ps
module sar_sample_to_display_index_tb;
    import ssdi_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               pixel_valid;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               done;
    logic [7:0]         color_index;
    logic signed [23:0] display_value;
    int                 fail_count;
    int                 pending_count;
    int                 result_count;
    int                 sent_count;
    int                 phase_count;
    bit                 quiet;

    sar_sample_to_display_index u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_re(sample_re), .sample_im(sample_im), .pixel_valid(pixel_valid),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .color_index(color_index),
        .display_value(display_value)
    );

    sar_sample_to_display_index_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_re(sample_re), .sample_im(sample_im), .pixel_valid(pixel_valid),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .color_index(color_index),
        .display_value(display_value), .fail_count(fail_count),
        .pending_count(pending_count), .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic push_pixel(logic signed [15:0] re, logic signed [15:0] im, logic pv);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        sample_re <= re;
        sample_im <= im;
        pixel_valid <= pv;
        do @(posedge clk); while (busy);
        sent_count++;
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic c, logic [2:0] m, logic [23:0] lo, logic [23:0] hi,
                           logic [15:0] fl);
        drain();
        write_reg(CFG_COMPLEX, {23'd0, c});
        write_reg(CFG_MODE, {21'd0, m});
        write_reg(CFG_RANGE_MIN, lo);
        write_reg(CFG_RANGE_MAX, hi);
        write_reg(CFG_FLOOR, {8'd0, fl});
        phase_count++;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(7)) - 16'sd3;
            1:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
            2:       return 16'($urandom_range(511)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [23:0] lo;
        logic [23:0] hi;
        logic [15:0] fl;
        logic [2:0]  m;
        int          n;
        rst_n = 1'b0;
        start = 1'b0;
        sample_re = '0;
        sample_im = '0;
        pixel_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COMPLEX;
        cfg_data = '0;
        sent_count = 0;
        phase_count = 0;
        quiet = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings first
        push_pixel(16'sh7fff, 16'sh7fff, 1'b1);
        push_pixel(-16'sd32768, -16'sd32768, 1'b1);
        push_pixel(16'sd3, 16'sd4, 1'b0);
        push_pixel(16'sd0, 16'sd0, 1'b1);
        set_all(1'b1, MODE_PHASE, -24'sd46080, 24'sd46080, 16'd0);
        push_pixel(16'sd0, 16'sd0, 1'b1);
        push_pixel(-16'sd5, 16'sd0, 1'b1);
        push_pixel(-16'sd32768, 16'sd1, 1'b1);
        push_pixel(16'sd0, -16'sd7, 1'b1);
        push_pixel(16'sd100, 16'sd100, 1'b1);
        set_all(1'b0, MODE_PHASE, 24'sd0, 24'sd256, 16'd0);
        push_pixel(16'sd5, 16'sd9, 1'b1);
        set_all(1'b0, MODE_IMAG, -24'sd10, 24'sd10, 16'd0);
        push_pixel(16'sd5, 16'sd9, 1'b1);
        set_all(1'b1, MODE_DB10, -24'sd8388608, 24'sd8388607, 16'd0);
        push_pixel(16'sd0, 16'sd0, 1'b1);
        push_pixel(16'sh7fff, -16'sd32768, 1'b1);
        set_all(1'b1, MODE_DB20, 24'sd0, 24'sd0, 16'hffff);
        push_pixel(16'sd0, 16'sd1, 1'b1);
        push_pixel(16'sh7fff, 16'sh7fff, 1'b1);
        set_all(1'b1, 3'd6, 24'sd0, -24'sd5, 16'd1);
        push_pixel(16'sd1, 16'sd1, 1'b1);
        set_all(1'b1, 3'd7, -24'sd1, 24'sd0, 16'd1);
        push_pixel(16'sd1, 16'sd1, 1'b1);
        set_all(1'b1, MODE_REAL, -24'sd2560, 24'sd2560, 16'd1);
        push_pixel(16'sd11, 16'sd0, 1'b1);
        push_pixel(-16'sd11, 16'sd0, 1'b1);
        push_pixel(16'sd3, 16'sd0, 1'b1);

        // random phases
        for (int ph = 0; ph < 16; ph++)
        begin
            quiet = (ph == 5);
            m = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            case ($urandom_range(4))
                0:
                begin
                    lo = 24'h800000;
                    hi = 24'h7fffff;
                end
                1:
                begin
                    lo = 24'($urandom);
                    hi = lo;
                end
                2:
                begin
                    lo = 24'($urandom);
                    hi = 24'($urandom);
                end
                default:
                begin
                    lo = 24'($urandom_range(131072)) - 24'd65536;
                    hi = lo + 24'($urandom_range(131072, 1));
                end
            endcase
            case ($urandom_range(3))
                0:       fl = 16'd0;
                1:       fl = 16'hffff;
                default: fl = 16'($urandom);
            endcase
            set_all(($urandom_range(4) != 0), m, lo, hi, fl);
            n = 28;
            repeat (n)
                push_pixel(rand_sample(), rand_sample(), ($urandom_range(9) != 0));
        end
        quiet = 1'b0;

        drain();
        $display("sent %0d pixel requests over %0d register settings, %0d results checked",
                 sent_count, phase_count, result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d failures, %0d results missing", fail_count, pending_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
